>>> hdl/cle_pkg.sv
// Package for the cursor list engine: sizes, codes, payload and control structs.
package cle_pkg;

    // Capacity of the list, the index and count widths that follow from it, and the data width.
    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // Operation codes.
    localparam logic [3:0] OP_PREPEND    = 4'd0;
    localparam logic [3:0] OP_APPEND     = 4'd1;
    localparam logic [3:0] OP_INS_BEFORE = 4'd2;
    localparam logic [3:0] OP_INS_AFTER  = 4'd3;
    localparam logic [3:0] OP_DEL_FRONT  = 4'd4;
    localparam logic [3:0] OP_DEL_BACK   = 4'd5;
    localparam logic [3:0] OP_DEL_CURSOR = 4'd6;
    localparam logic [3:0] OP_MV_FRONT   = 4'd7;
    localparam logic [3:0] OP_MV_BACK    = 4'd8;
    localparam logic [3:0] OP_MV_PREV    = 4'd9;
    localparam logic [3:0] OP_MV_NEXT    = 4'd10;
    localparam logic [3:0] OP_SET        = 4'd11;
    localparam logic [3:0] OP_CLEAR      = 4'd12;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_NOCUR = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // Commands broadcast along the row of cells.
    localparam logic [1:0] CMD_HOLD  = 2'd0;
    localparam logic [1:0] CMD_OPEN  = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;
    localparam logic [1:0] CMD_WRITE = 2'd3;

    typedef struct packed {
        logic [3:0]               op;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [CNT_W-1:0]         list_length;
        logic                     cursor_defined;
        logic [IDX_W-1:0]         cursor_index;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic signed [DATA_W-1:0] cursor_value;
    } rsp_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [IDX_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] cur_pos;
        logic             cur_valid;
        logic [1:0]       status;
    } view_t;

endpackage

>>> hdl/cle_cell.sv
// One list cell: holds one element and shifts toward either neighbor on command.
module cle_cell
(
    input  logic                         clk,
    input  logic [cle_pkg::IDX_W-1:0]    index,
    input  cle_pkg::cmd_t                cmd,
    input  cle_pkg::view_t               view,
    input  logic [cle_pkg::DATA_W-1:0]   left_data,
    input  logic [cle_pkg::DATA_W-1:0]   right_data,
    output logic [cle_pkg::DATA_W-1:0]   data,
    output logic [cle_pkg::DATA_W-1:0]   back_tap,
    output logic [cle_pkg::DATA_W-1:0]   cur_tap
);

    logic [cle_pkg::DATA_W-1:0] data_reg;
    logic [cle_pkg::DATA_W-1:0] data_next;
    logic                       is_back;
    logic                       is_cur;

    // Select the new content from the broadcast command and this cell's place.
    always_comb
    begin
        data_next = data_reg;
        case (cmd.kind)
            cle_pkg::CMD_OPEN:
            begin
                if (index == cmd.pos)
                begin
                    data_next = cmd.value;
                end
                else if (index > cmd.pos)
                begin
                    data_next = left_data;
                end
            end
            cle_pkg::CMD_CLOSE:
            begin
                if (index >= cmd.pos)
                begin
                    data_next = right_data;
                end
            end
            cle_pkg::CMD_WRITE:
            begin
                if (index == cmd.pos)
                begin
                    data_next = cmd.value;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // Offer the content on the back and cursor taps when this cell holds them.
    assign is_back = (view.count != '0) &&
                     ({1'b0, index} == (view.count - cle_pkg::CNT_W'(1)));
    assign is_cur  = view.cur_valid && (index == view.cur_pos);

    assign data     = data_reg;
    assign back_tap = is_back ? data_reg : '0;
    assign cur_tap  = is_cur ? data_reg : '0;

endmodule

>>> hdl/cle_ctrl.sv
// Controller: length and cursor registers, operation decode and cell commands.
module cle_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  cle_pkg::req_t   req,
    output cle_pkg::cmd_t   cmd,
    output cle_pkg::view_t  view
);

    logic [cle_pkg::CNT_W-1:0] count_reg;
    logic [cle_pkg::CNT_W-1:0] count_next;
    logic [cle_pkg::IDX_W-1:0] cur_pos_reg;
    logic [cle_pkg::IDX_W-1:0] cur_pos_next;
    logic                      cur_valid_reg;
    logic                      cur_valid_next;
    logic [1:0]                status_reg;
    logic [1:0]                status_next;
    logic                      empty;
    logic                      full;
    logic [cle_pkg::CNT_W-1:0] cur_plus_one;
    cle_pkg::cmd_t             cmd_raw;

    assign empty        = (count_reg == '0);
    assign full         = (count_reg == cle_pkg::CNT_W'(cle_pkg::DEPTH));
    assign cur_plus_one = {1'b0, cur_pos_reg} + cle_pkg::CNT_W'(1);

    // Decode the operation into the next length, cursor, status and cell command.
    always_comb
    begin
        count_next     = count_reg;
        cur_pos_next   = cur_pos_reg;
        cur_valid_next = cur_valid_reg;
        status_next    = cle_pkg::ST_OK;
        cmd_raw.kind   = cle_pkg::CMD_HOLD;
        cmd_raw.pos    = '0;
        cmd_raw.value  = req.value;
        case (req.op)
            cle_pkg::OP_PREPEND:
            begin
                if (full)
                begin
                    status_next = cle_pkg::ST_FULL;
                end
                else
                begin
                    cmd_raw.kind = cle_pkg::CMD_OPEN;
                    count_next   = count_reg + cle_pkg::CNT_W'(1);
                    if (cur_valid_reg)
                    begin
                        cur_pos_next = cur_pos_reg + cle_pkg::IDX_W'(1);
                    end
                end
            end
            cle_pkg::OP_APPEND:
            begin
                if (full)
                begin
                    status_next = cle_pkg::ST_FULL;
                end
                else
                begin
                    cmd_raw.kind = cle_pkg::CMD_OPEN;
                    cmd_raw.pos  = count_reg[cle_pkg::IDX_W-1:0];
                    count_next   = count_reg + cle_pkg::CNT_W'(1);
                end
            end
            cle_pkg::OP_INS_BEFORE, cle_pkg::OP_INS_AFTER:
            begin
                if (empty)
                begin
                    status_next = cle_pkg::ST_EMPTY;
                end
                else if (!cur_valid_reg)
                begin
                    status_next = cle_pkg::ST_NOCUR;
                end
                else if (full)
                begin
                    status_next = cle_pkg::ST_FULL;
                end
                else
                begin
                    cmd_raw.kind = cle_pkg::CMD_OPEN;
                    count_next   = count_reg + cle_pkg::CNT_W'(1);
                    if (req.op == cle_pkg::OP_INS_BEFORE)
                    begin
                        cmd_raw.pos  = cur_pos_reg;
                        cur_pos_next = cur_pos_reg + cle_pkg::IDX_W'(1);
                    end
                    else
                    begin
                        cmd_raw.pos = cur_plus_one[cle_pkg::IDX_W-1:0];
                    end
                end
            end
            cle_pkg::OP_DEL_FRONT:
            begin
                if (empty)
                begin
                    status_next = cle_pkg::ST_EMPTY;
                end
                else
                begin
                    cmd_raw.kind = cle_pkg::CMD_CLOSE;
                    count_next   = count_reg - cle_pkg::CNT_W'(1);
                    if (cur_valid_reg)
                    begin
                        if (cur_pos_reg == '0)
                        begin
                            cur_valid_next = 1'b0;
                        end
                        else
                        begin
                            cur_pos_next = cur_pos_reg - cle_pkg::IDX_W'(1);
                        end
                    end
                end
            end
            cle_pkg::OP_DEL_BACK:
            begin
                if (empty)
                begin
                    status_next = cle_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - cle_pkg::CNT_W'(1);
                    if (cur_valid_reg && (cur_plus_one == count_reg))
                    begin
                        cur_valid_next = 1'b0;
                    end
                end
            end
            cle_pkg::OP_DEL_CURSOR:
            begin
                if (empty)
                begin
                    status_next = cle_pkg::ST_EMPTY;
                end
                else if (!cur_valid_reg)
                begin
                    status_next = cle_pkg::ST_NOCUR;
                end
                else
                begin
                    cmd_raw.kind   = cle_pkg::CMD_CLOSE;
                    cmd_raw.pos    = cur_pos_reg;
                    count_next     = count_reg - cle_pkg::CNT_W'(1);
                    cur_valid_next = 1'b0;
                end
            end
            cle_pkg::OP_MV_FRONT:
            begin
                if (empty)
                begin
                    status_next = cle_pkg::ST_EMPTY;
                end
                else
                begin
                    cur_valid_next = 1'b1;
                    cur_pos_next   = '0;
                end
            end
            cle_pkg::OP_MV_BACK:
            begin
                if (empty)
                begin
                    status_next = cle_pkg::ST_EMPTY;
                end
                else
                begin
                    cur_valid_next = 1'b1;
                    cur_pos_next   = count_reg[cle_pkg::IDX_W-1:0] - cle_pkg::IDX_W'(1);
                end
            end
            cle_pkg::OP_MV_PREV:
            begin
                if (cur_valid_reg)
                begin
                    if (cur_pos_reg == '0)
                    begin
                        cur_valid_next = 1'b0;
                    end
                    else
                    begin
                        cur_pos_next = cur_pos_reg - cle_pkg::IDX_W'(1);
                    end
                end
            end
            cle_pkg::OP_MV_NEXT:
            begin
                if (cur_valid_reg)
                begin
                    if (cur_plus_one >= count_reg)
                    begin
                        cur_valid_next = 1'b0;
                    end
                    else
                    begin
                        cur_pos_next = cur_plus_one[cle_pkg::IDX_W-1:0];
                    end
                end
            end
            cle_pkg::OP_SET:
            begin
                if (empty)
                begin
                    status_next = cle_pkg::ST_EMPTY;
                end
                else if (!cur_valid_reg)
                begin
                    status_next = cle_pkg::ST_NOCUR;
                end
                else
                begin
                    cmd_raw.kind = cle_pkg::CMD_WRITE;
                    cmd_raw.pos  = cur_pos_reg;
                end
            end
            cle_pkg::OP_CLEAR:
            begin
                count_next     = '0;
                cur_valid_next = 1'b0;
            end
            default:
            begin
                status_next = cle_pkg::ST_OK;
            end
        endcase

        // A cursor past the end of the list, or on an empty list, is undefined.
        if ((count_next == '0) || ({1'b0, cur_pos_next} >= count_next))
        begin
            cur_valid_next = 1'b0;
        end
        // The position is kept at zero while the cursor is undefined.
        if (!cur_valid_next)
        begin
            cur_pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cur_pos_reg   <= '0;
            cur_valid_reg <= 1'b0;
            status_reg    <= cle_pkg::ST_OK;
        end
        else if (accept)
        begin
            count_reg     <= count_next;
            cur_pos_reg   <= cur_pos_next;
            cur_valid_reg <= cur_valid_next;
            status_reg    <= status_next;
        end
    end

    // Cells move only on the cycle that a request transfer is taken.
    always_comb
    begin
        cmd      = cmd_raw;
        cmd.kind = accept ? cmd_raw.kind : cle_pkg::CMD_HOLD;
    end

    assign view.count     = count_reg;
    assign view.cur_pos   = cur_pos_reg;
    assign view.cur_valid = cur_valid_reg;
    assign view.status    = status_reg;

endmodule

>>> hdl/cursor_list_engine_top.sv
// Top level of the cursor list engine: row of cells, controller and result register.
//
//   Channel | Signals                   | Payload | Role
//   --------+---------------------------+---------+-----------------------------
//   request | req_valid, req_stall, req | req_t   | operation code and value in
//   result  | rsp_valid, rsp_stall, rsp | rsp_t   | status, length, cursor, values
//
// At the transfer edge the cells shift or are written in parallel as the operation
// needs, and length and cursor are updated; the result register is then loaded from
// the cell taps once it is free. req_stall stays high from the transfer until that
// load, so no new request is taken while one is pending. A waiting result does not
// block the next transfer; its gather holds until the result register frees. Reset
// empties the list and leaves the cursor undefined; cell contents are not cleared.
module cursor_list_engine_top
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  cle_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output cle_pkg::rsp_t  rsp
);

    logic                        accept;
    logic                        pend_reg;
    logic                        pend_next;
    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;
    logic                        load;
    cle_pkg::rsp_t               rsp_reg;
    cle_pkg::rsp_t               rsp_next;
    cle_pkg::cmd_t               cmd;
    cle_pkg::view_t              view;
    logic [cle_pkg::DATA_W-1:0]  cell_data [cle_pkg::DEPTH];
    logic [cle_pkg::DATA_W-1:0]  back_tap  [cle_pkg::DEPTH];
    logic [cle_pkg::DATA_W-1:0]  cur_tap   [cle_pkg::DEPTH];
    logic [cle_pkg::DATA_W-1:0]  back_any;
    logic [cle_pkg::DATA_W-1:0]  cur_any;

    // Request handshake: one operation in flight between transfer and gather.
    assign req_stall = pend_reg;
    assign accept    = req_valid && !pend_reg;

    cle_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .cmd    (cmd),
        .view   (view)
    );

    // The row of cells; the ends see zero beyond the list.
    for (genvar i = 0; i < cle_pkg::DEPTH; i++)
    begin : g_cell
        logic [cle_pkg::DATA_W-1:0] left_data;
        logic [cle_pkg::DATA_W-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = '0;
        end
        else
        begin : g_inner_l
            assign left_data = cell_data[i-1];
        end

        if (i == cle_pkg::DEPTH - 1)
        begin : g_last
            assign right_data = '0;
        end
        else
        begin : g_inner_r
            assign right_data = cell_data[i+1];
        end

        cle_cell u_cell
        (
            .clk        (clk),
            .index      (cle_pkg::IDX_W'(i)),
            .cmd        (cmd),
            .view       (view),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i]),
            .back_tap   (back_tap[i]),
            .cur_tap    (cur_tap[i])
        );
    end

    // At most one cell drives each tap, so the taps are merged by OR.
    always_comb
    begin
        back_any = '0;
        cur_any  = '0;
        for (int k = 0; k < cle_pkg::DEPTH; k++)
        begin
            back_any = back_any | back_tap[k];
            cur_any  = cur_any | cur_tap[k];
        end
    end

    // Assemble the result from the updated state.
    always_comb
    begin
        rsp_next.status         = view.status;
        rsp_next.list_length    = view.count;
        rsp_next.cursor_defined = view.cur_valid;
        rsp_next.cursor_index   = view.cur_pos;
        rsp_next.front_value    = (view.count != '0) ? cell_data[0] : '0;
        rsp_next.back_value     = back_any;
        rsp_next.cursor_value   = cur_any;
    end

    // Gather and result register control.
    assign load = pend_reg && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        pend_next      = pend_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (load)
        begin
            pend_next      = 1'b0;
            rsp_valid_next = 1'b1;
        end
        if (accept)
        begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
